// ===== rtl/core/esu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esu_pkg;

    // Queue of decoded groups between front and back
    localparam int QUEUE_DEPTH = 2;

    // Up to three decoded bytes come out of one raw byte
    localparam int GRP_MAX = 3;
    localparam int GRP_CNT_W = $clog2(GRP_MAX + 1);
    localparam int GRP_IDX_W = $clog2(GRP_MAX);

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_X   = 8'h78;

    // One decoded group: count of valid bytes, the bytes in order, and the
    // end-of-string mark carried by the final byte of the group
    typedef struct packed {
        logic [GRP_CNT_W-1:0]    cnt;
        logic [GRP_MAX-1:0][7:0] bytes;
        logic                    last;
    } grp_t;

    // Hex digit: bit 4 set when the byte is a digit, bits 3:0 its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Single-letter escape: bit 8 set when known, bits 7:0 the decoded byte
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        unique case (b)
            8'h45:   r = {1'b1, 8'd27};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h74:   r = {1'b1, 8'd9};
            8'h72:   r = {1'b1, 8'd13};
            8'h6E:   r = {1'b1, 8'd10};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    output logic              push_valid,
    input  wire logic         push_ready,
    output esu_pkg::grp_t     push_data
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BSL  = 2'd1;
    localparam logic [1:0] PH_X    = 2'd2;
    localparam logic [1:0] PH_HEX1 = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    held_reg, held_next;
    logic          accept;
    logic          fresh_emit;
    logic [4:0]    hex;
    logic [8:0]    esc;
    esu_pkg::grp_t grp;

    // Accept whenever the queue has room; empty groups are not queued
    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && (grp.cnt != '0);
    assign push_data  = grp;

    assign hex = esu_pkg::hex_value(in_byte);
    assign esc = esu_pkg::simple_escape(in_byte);
    // A backslash that is not last opens an escape; anything else goes out
    assign fresh_emit = !(in_byte == esu_pkg::CH_BSL && !in_last);

    // Classify the request against the pending escape
    always_comb
    begin
        grp        = '0;
        grp.last   = in_last;
        phase_next = phase_reg;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                grp.bytes[0] = in_byte;
                grp.cnt      = fresh_emit ? esu_pkg::GRP_CNT_W'(1) : '0;
                phase_next   = fresh_emit ? PH_IDLE : PH_BSL;
            end
            PH_BSL:
            begin
                if (esc[8]) begin
                    grp.bytes[0] = esc[7:0];
                    grp.cnt      = esu_pkg::GRP_CNT_W'(1);
                    phase_next   = PH_IDLE;
                end
                else if (in_byte == esu_pkg::CH_X) begin
                    grp.bytes[0] = esu_pkg::CH_BSL;
                    grp.bytes[1] = esu_pkg::CH_X;
                    grp.cnt      = in_last ? esu_pkg::GRP_CNT_W'(2) : '0;
                    phase_next   = in_last ? PH_IDLE : PH_X;
                end
                else begin
                    grp.bytes[0] = esu_pkg::CH_BSL;
                    grp.bytes[1] = in_byte;
                    grp.cnt      = fresh_emit ? esu_pkg::GRP_CNT_W'(2)
                                              : esu_pkg::GRP_CNT_W'(1);
                    phase_next   = fresh_emit ? PH_IDLE : PH_BSL;
                end
            end
            PH_X:
            begin
                if (hex[4]) begin
                    grp.bytes[0] = {4'd0, hex[3:0]};
                    grp.cnt      = in_last ? esu_pkg::GRP_CNT_W'(1) : '0;
                    held_next    = in_last ? held_reg : hex[3:0];
                    phase_next   = in_last ? PH_IDLE : PH_HEX1;
                end
                else begin
                    grp.bytes[0] = esu_pkg::CH_BSL;
                    grp.bytes[1] = esu_pkg::CH_X;
                    grp.bytes[2] = in_byte;
                    grp.cnt      = fresh_emit ? esu_pkg::GRP_CNT_W'(3)
                                              : esu_pkg::GRP_CNT_W'(2);
                    phase_next   = fresh_emit ? PH_IDLE : PH_BSL;
                end
            end
            PH_HEX1:
            begin
                if (hex[4]) begin
                    grp.bytes[0] = {held_reg, hex[3:0]};
                    grp.cnt      = esu_pkg::GRP_CNT_W'(1);
                    phase_next   = PH_IDLE;
                end
                else begin
                    grp.bytes[0] = {4'd0, held_reg};
                    grp.bytes[1] = in_byte;
                    grp.cnt      = fresh_emit ? esu_pkg::GRP_CNT_W'(2)
                                              : esu_pkg::GRP_CNT_W'(1);
                    phase_next   = fresh_emit ? PH_IDLE : PH_BSL;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance escape state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 4'd0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

`ifndef ASSERT_OFF
    // The end of a string always leaves no escape pending
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> phase_reg == PH_IDLE)
        else $error("escape pending after end of string");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/esu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esu_queue #(
    parameter int DEPTH = esu_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire esu_pkg::grp_t  push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output esu_pkg::grp_t       pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    esu_pkg::grp_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 push, pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold group storage; written only on push
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    // Only groups that carry bytes are ever queued
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_data.cnt != '0)
        else $error("empty group queued");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/esu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire esu_pkg::grp_t  pop_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg;
    logic                          out_last_reg;
    logic [esu_pkg::GRP_IDX_W-1:0] idx_reg, idx_next;
    logic                          load, take, final_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Output register is free when empty or being drained this cycle
    assign load       = !out_valid_reg || out_ready;
    assign take       = load && pop_valid;
    assign final_byte = (esu_pkg::GRP_CNT_W'(idx_reg) == pop_data.cnt - 1'b1);
    assign pop_ready  = take && final_byte;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take) begin
            out_valid_next = 1'b1;
            idx_next       = final_byte ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Load the next byte of the head group
    always_ff @(posedge clk)
    begin
        if (take) begin
            out_byte_reg <= pop_data.bytes[idx_reg];
            out_last_reg <= pop_data.last && final_byte;
        end
    end

`ifndef ASSERT_OFF
    // Position within the head group stays inside its byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> esu_pkg::GRP_CNT_W'(idx_reg) < pop_data.cnt)
        else $error("group index past byte count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/escape_sequence_unescaper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    in_byte[7:0], in_last
// output    out        out_valid/out_ready  out_byte[7:0], out_last
//
// One raw byte accepted per cycle while the group queue has room.
// Each raw byte yields zero to three decoded bytes; the back end sends one
// decoded byte per cycle while out_ready is high.
// From accept, a decoded byte passes the queue register, then the output reg.
// rst_n clears escape state, queue pointers and output valid asynchronously.
// Output stalls back up through the QUEUE_DEPTH-entry group queue to in_ready.

module escape_sequence_unescaper #(
    parameter int QUEUE_DEPTH = esu_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;
    esu_pkg::grp_t push_data, pop_data;

    esu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    esu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    esu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire
